[hdl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion clocked on clk, held off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form of the above.
`define ASSERT_IMPL(label, pre, post, msg) \
	`ASSERT_CLK(label, (pre) |-> (post), msg)

`endif

[hdl/csp_pkg.sv]
// Package: sizes, codes and helpers of the sparse product block.
package csp_pkg;

	localparam int MAX_DIM      = 64;
	localparam int DIM_BITS     = $clog2(MAX_DIM);
	localparam int CNT_BITS     = 7;
	localparam int MAX_NZ       = 1024;
	localparam int NZ_BITS      = $clog2(MAX_NZ);
	localparam int FILL_BITS    = NZ_BITS + 1;
	localparam int VALUE_BITS   = 32;
	localparam int IN_VAL_BITS  = 32;
	localparam int ACC_BITS     = 48;
	localparam int PROD_BITS    = 2 * VALUE_BITS;
	localparam int FRAC_BITS    = 16;
	localparam int C_DEPTH      = MAX_DIM * MAX_DIM;
	localparam int C_ADDR_BITS  = 2 * DIM_BITS;
	localparam int A_WIDTH      = 2 * DIM_BITS + VALUE_BITS;
	localparam int B_WIDTH      = DIM_BITS + VALUE_BITS;
	localparam int RNG_WIDTH    = 2 * FILL_BITS;
	localparam int IN_DATA_BITS = ((2 * DIM_BITS + IN_VAL_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((ACC_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_READ_C = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DIM_ERR  = 2'd1,
		ST_FULL_ERR = 2'd2,
		ST_RANGE_ERR = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_A_ROWS  = 3'd0,
		REG_A_COLS  = 3'd1,
		REG_B_ROWS  = 3'd2,
		REG_B_COLS  = 3'd3,
		REG_UPPER   = 3'd4
	} reg_idx_t;

	// Counts above MAX_DIM act as MAX_DIM.
	function automatic logic [CNT_BITS-1:0] eff_dim(input logic [CNT_BITS-1:0] v);
		logic [CNT_BITS-1:0] lim;
		lim = CNT_BITS'(MAX_DIM);
		return (v > lim) ? lim : v;
	endfunction

endpackage

[hdl/csp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module csp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/csp_mac.sv]
// Shared multiply, round and saturating accumulate unit.
module csp_mac (
	input  logic                                    clk,
	input  logic                                    mul_en,
	input  logic                                    rnd_en,
	input  logic signed [csp_pkg::VALUE_BITS-1:0]   a_val,
	input  logic signed [csp_pkg::VALUE_BITS-1:0]   b_val,
	input  logic signed [csp_pkg::ACC_BITS-1:0]     acc_in,
	output logic signed [csp_pkg::ACC_BITS-1:0]     acc_out,
	output logic                                    acc_sat
);

	logic signed [csp_pkg::PROD_BITS-1:0] prod_s1;
	logic signed [csp_pkg::ACC_BITS-1:0]  term_s2;
	logic signed [csp_pkg::PROD_BITS-1:0] rounded;
	logic signed [csp_pkg::ACC_BITS:0]    sum;

	// Q32.32 product to Q32.16, round half up then floor.
	assign rounded = (prod_s1 + csp_pkg::PROD_BITS'(1 << (csp_pkg::FRAC_BITS - 1)))
		>>> csp_pkg::FRAC_BITS;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= a_val * b_val;
		end
		if (rnd_en) begin
			term_s2 <= csp_pkg::ACC_BITS'(rounded);
		end
	end

	always_comb begin
		sum = {acc_in[csp_pkg::ACC_BITS-1], acc_in} + {term_s2[csp_pkg::ACC_BITS-1], term_s2};
		acc_sat = (sum[csp_pkg::ACC_BITS] != sum[csp_pkg::ACC_BITS-1]);
		if (!acc_sat) begin
			acc_out = sum[csp_pkg::ACC_BITS-1:0];
		end else if (sum[csp_pkg::ACC_BITS]) begin
			acc_out = {1'b1, {(csp_pkg::ACC_BITS-1){1'b0}}};
		end else begin
			acc_out = {1'b0, {(csp_pkg::ACC_BITS-1){1'b1}}};
		end
	end

endmodule

[hdl/sparse_csr_product_to_dense.sv]
// Sparse A times sparse B into dense C: sequencer, stores and ports.
//
// Items enter on s_axis (tuser = command, tdata = row, column, value) and one
// result per item leaves on m_axis (tdata = C value, tuser = status and
// saturated flag). Registers are written on the cfg channel, which is always
// ready; write them only while the block is idle.
// Load A/B items go through S_RESP, read C items through S_C_RD and S_RESP.
// A compute item first sweeps all 4096 C entries to zero, one entry a cycle,
// then reads and checks each stored A nonzero, fetches the B row range for
// each in range, reads and checks each B nonzero visited and multiplies and
// accumulates each product kept, on one shared MAC unit and one C port set.
// The block takes one item at a time; s_axis_tready is low while an item is
// at work.
// After reset the same clear of C runs with s_axis_tready low;
// all stores are empty and registers hold their reset values.
// Results wait in an output register while m_axis_tready is low; the block
// may accept one more item meanwhile but holds its result until the
// output register is free.
`include "assert_macros.svh"

module sparse_csr_product_to_dense (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [5:0] row_index, [11:6] col_index, [43:12] entry_value, rest zero
	input  logic [csp_pkg::IN_DATA_BITS-1:0]       s_axis_tdata,
	// [1:0] cmd
	input  logic [1:0]                             s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [47:0] c_value
	output logic [csp_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
	// [1:0] status, [2] saturated
	output logic [2:0]                             m_axis_tuser,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [csp_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [csp_pkg::CNT_BITS-1:0]           cfg_data
);

	localparam int DB = csp_pkg::DIM_BITS;
	localparam int FB = csp_pkg::FILL_BITS;
	localparam int NB = csp_pkg::NZ_BITS;
	localparam int VB = csp_pkg::VALUE_BITS;
	localparam int AB = csp_pkg::ACC_BITS;
	localparam int CB = csp_pkg::C_ADDR_BITS;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_CLEAR = 11'b00000000010,
		S_A_RD  = 11'b00000000100,
		S_A_CHK = 11'b00000001000,
		S_RNG   = 11'b00000010000,
		S_B_RD  = 11'b00000100000,
		S_B_CHK = 11'b00001000000,
		S_MUL   = 11'b00010000000,
		S_ACC   = 11'b00100000000,
		S_C_RD  = 11'b01000000000,
		S_RESP  = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [csp_pkg::CNT_BITS-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic                         upper_q;
	logic [csp_pkg::CNT_BITS-1:0] a_rows_e, a_cols_e, b_rows_e, b_cols_e;

	logic [FB-1:0] a_fill_q, b_fill_q;
	logic [DB-1:0] a_last_row_q, b_last_row_q;
	logic [FB-1:0] b_row_start_q;
	logic [csp_pkg::MAX_DIM-1:0] rng_valid_q;

	logic [CB-1:0] clr_q;
	logic          clr_compute_q;
	logic [FB-1:0] a_idx_q, k_q, kend_q;
	logic          rng_hit_q;
	logic [DB-1:0] n_q;
	logic          sat_q;

	logic [AB-1:0] res_value_q;
	csp_pkg::status_t res_status_q;
	logic          res_sat_q;
	logic          out_valid_q;
	logic [AB-1:0] out_value_q;
	csp_pkg::status_t out_status_q;
	logic          out_sat_q;

	logic             accept;
	csp_pkg::cmd_t    in_cmd;
	logic [DB-1:0]    in_row, in_col;
	logic [VB-1:0]    in_val;

	logic             a_wr_en, b_wr_en, rng_wr_en;
	logic             a_rd_en, b_rd_en, rng_rd_en, c_rd_en, c_wr_en;
	logic [csp_pkg::A_WIDTH-1:0]   a_rd_data;
	logic [csp_pkg::B_WIDTH-1:0]   b_rd_data;
	logic [csp_pkg::RNG_WIDTH-1:0] rng_rd_data;
	logic [AB-1:0]    c_rd_data, c_wr_data;
	logic [CB-1:0]    c_wr_addr, c_rd_addr;
	logic [FB-1:0]    b_start_new;

	logic [DB-1:0]    a_row, a_col;
	logic [VB-1:0]    a_val;
	logic [DB-1:0]    b_col;
	logic [VB-1:0]    b_val;
	logic             mul_en, rnd_en;
	logic signed [AB-1:0] acc_out;
	logic             acc_sat;

	csp_pkg::status_t load_a_st, load_b_st;
	logic             read_bad;

	assign a_rows_e = csp_pkg::eff_dim(a_rows_q);
	assign a_cols_e = csp_pkg::eff_dim(a_cols_q);
	assign b_rows_e = csp_pkg::eff_dim(b_rows_q);
	assign b_cols_e = csp_pkg::eff_dim(b_cols_q);

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	assign in_cmd = csp_pkg::cmd_t'(s_axis_tuser);
	assign in_row = s_axis_tdata[DB-1:0];
	assign in_col = s_axis_tdata[2*DB-1:DB];
	assign in_val = s_axis_tdata[2*DB +: VB];

	assign {a_row, a_col, a_val} = a_rd_data;
	assign {b_col, b_val} = b_rd_data;

	always_comb begin
		if ({1'b0, in_row} >= a_rows_e || {1'b0, in_col} >= a_cols_e) begin
			load_a_st = csp_pkg::ST_RANGE_ERR;
		end else if (a_fill_q == FB'(csp_pkg::MAX_NZ)
				|| (a_fill_q != '0 && in_row < a_last_row_q)) begin
			load_a_st = csp_pkg::ST_FULL_ERR;
		end else begin
			load_a_st = csp_pkg::ST_OK;
		end
		if ({1'b0, in_row} >= b_rows_e || {1'b0, in_col} >= b_cols_e) begin
			load_b_st = csp_pkg::ST_RANGE_ERR;
		end else if (b_fill_q == FB'(csp_pkg::MAX_NZ)
				|| (b_fill_q != '0 && in_row < b_last_row_q)) begin
			load_b_st = csp_pkg::ST_FULL_ERR;
		end else begin
			load_b_st = csp_pkg::ST_OK;
		end
		read_bad = ({1'b0, in_row} >= a_rows_e || {1'b0, in_col} >= b_cols_e);
	end

	// Start of the current B row: reuse it while the same row keeps loading.
	assign b_start_new = (b_fill_q != '0 && in_row == b_last_row_q) ? b_row_start_q : b_fill_q;

	assign a_wr_en = accept && in_cmd == csp_pkg::CMD_LOAD_A && load_a_st == csp_pkg::ST_OK;
	assign b_wr_en = accept && in_cmd == csp_pkg::CMD_LOAD_B && load_b_st == csp_pkg::ST_OK;
	assign rng_wr_en = b_wr_en;

	assign a_rd_en = (state_q == S_A_RD) && (a_idx_q != a_fill_q);
	assign b_rd_en = (state_q == S_B_RD) && (k_q != kend_q);
	assign rng_rd_en = (state_q == S_A_CHK);
	assign mul_en = (state_q == S_B_CHK);
	assign rnd_en = (state_q == S_MUL);

	always_comb begin
		c_rd_en = 1'b0;
		c_rd_addr = {a_row, b_col};
		if (accept && in_cmd == csp_pkg::CMD_READ_C) begin
			c_rd_en = !read_bad;
			c_rd_addr = {in_row, in_col};
		end else if (state_q == S_B_CHK) begin
			c_rd_en = 1'b1;
		end
		c_wr_en = 1'b0;
		c_wr_addr = clr_q;
		c_wr_data = '0;
		if (state_q == S_CLEAR) begin
			c_wr_en = 1'b1;
		end else if (state_q == S_ACC) begin
			c_wr_en = 1'b1;
			c_wr_addr = {a_row, n_q};
			c_wr_data = acc_out;
		end
	end

	csp_ram #(.WIDTH(csp_pkg::A_WIDTH), .DEPTH(csp_pkg::MAX_NZ)) u_a_ram (
		.clk(clk), .wr_en(a_wr_en), .wr_addr(a_fill_q[NB-1:0]),
		.wr_data({in_row, in_col, in_val}),
		.rd_en(a_rd_en), .rd_addr(a_idx_q[NB-1:0]), .rd_data(a_rd_data)
	);

	csp_ram #(.WIDTH(csp_pkg::B_WIDTH), .DEPTH(csp_pkg::MAX_NZ)) u_b_ram (
		.clk(clk), .wr_en(b_wr_en), .wr_addr(b_fill_q[NB-1:0]),
		.wr_data({in_col, in_val}),
		.rd_en(b_rd_en), .rd_addr(k_q[NB-1:0]), .rd_data(b_rd_data)
	);

	// Per B row: first and one-past-last nonzero index.
	csp_ram #(.WIDTH(csp_pkg::RNG_WIDTH), .DEPTH(csp_pkg::MAX_DIM)) u_rng_ram (
		.clk(clk), .wr_en(rng_wr_en), .wr_addr(in_row),
		.wr_data({b_start_new, b_fill_q + FB'(1)}),
		.rd_en(rng_rd_en), .rd_addr(a_col), .rd_data(rng_rd_data)
	);

	csp_ram #(.WIDTH(AB), .DEPTH(csp_pkg::C_DEPTH)) u_c_ram (
		.clk(clk), .wr_en(c_wr_en), .wr_addr(c_wr_addr), .wr_data(c_wr_data),
		.rd_en(c_rd_en), .rd_addr(c_rd_addr), .rd_data(c_rd_data)
	);

	csp_mac u_mac (
		.clk(clk), .mul_en(mul_en), .rnd_en(rnd_en),
		.a_val(a_val), .b_val(b_val),
		.acc_in(c_rd_data), .acc_out(acc_out), .acc_sat(acc_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= csp_pkg::CNT_BITS'(csp_pkg::MAX_DIM);
			a_cols_q <= csp_pkg::CNT_BITS'(csp_pkg::MAX_DIM);
			b_rows_q <= csp_pkg::CNT_BITS'(csp_pkg::MAX_DIM);
			b_cols_q <= csp_pkg::CNT_BITS'(csp_pkg::MAX_DIM);
			upper_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				csp_pkg::REG_A_ROWS: a_rows_q <= cfg_data;
				csp_pkg::REG_A_COLS: a_cols_q <= cfg_data;
				csp_pkg::REG_B_ROWS: b_rows_q <= cfg_data;
				csp_pkg::REG_B_COLS: b_cols_q <= cfg_data;
				csp_pkg::REG_UPPER:  upper_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			a_fill_q <= '0;
			b_fill_q <= '0;
			a_last_row_q <= '0;
			b_last_row_q <= '0;
			b_row_start_q <= '0;
			rng_valid_q <= '0;
			clr_q <= '0;
			clr_compute_q <= 1'b0;
			a_idx_q <= '0;
			k_q <= '0;
			kend_q <= '0;
			rng_hit_q <= 1'b0;
			n_q <= '0;
			sat_q <= 1'b0;
			res_value_q <= '0;
			res_status_q <= csp_pkg::ST_OK;
			res_sat_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_status_q <= csp_pkg::ST_OK;
			out_sat_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_value_q <= '0;
						res_sat_q <= 1'b0;
						state_q <= S_RESP;
						case (in_cmd)
							csp_pkg::CMD_LOAD_A: begin
								res_status_q <= load_a_st;
								if (a_wr_en) begin
									a_fill_q <= a_fill_q + FB'(1);
									a_last_row_q <= in_row;
								end
							end
							csp_pkg::CMD_LOAD_B: begin
								res_status_q <= load_b_st;
								if (b_wr_en) begin
									b_fill_q <= b_fill_q + FB'(1);
									b_last_row_q <= in_row;
									b_row_start_q <= b_start_new;
									rng_valid_q[in_row] <= 1'b1;
								end
							end
							csp_pkg::CMD_COMPUTE: begin
								if (!upper_q && a_cols_q != b_rows_q) begin
									res_status_q <= csp_pkg::ST_DIM_ERR;
								end else begin
									res_status_q <= csp_pkg::ST_OK;
									clr_compute_q <= 1'b1;
									clr_q <= '0;
									state_q <= S_CLEAR;
								end
							end
							csp_pkg::CMD_READ_C: begin
								if (read_bad) begin
									res_status_q <= csp_pkg::ST_RANGE_ERR;
								end else begin
									res_status_q <= csp_pkg::ST_OK;
									state_q <= S_C_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + CB'(1);
					if (clr_q == '1) begin
						if (clr_compute_q) begin
							clr_compute_q <= 1'b0;
							a_idx_q <= '0;
							sat_q <= 1'b0;
							state_q <= S_A_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_A_RD: begin
					if (a_idx_q == a_fill_q) begin
						res_sat_q <= sat_q;
						state_q <= S_RESP;
					end else begin
						state_q <= S_A_CHK;
					end
				end
				S_A_CHK: begin
					if ({1'b0, a_row} >= a_rows_e) begin
						a_idx_q <= a_idx_q + FB'(1);
						state_q <= S_A_RD;
					end else begin
						rng_hit_q <= rng_valid_q[a_col];
						state_q <= S_RNG;
					end
				end
				S_RNG: begin
					if (rng_hit_q) begin
						{k_q, kend_q} <= rng_rd_data;
					end else begin
						k_q <= '0;
						kend_q <= '0;
					end
					state_q <= S_B_RD;
				end
				S_B_RD: begin
					if (k_q == kend_q) begin
						a_idx_q <= a_idx_q + FB'(1);
						state_q <= S_A_RD;
					end else begin
						state_q <= S_B_CHK;
					end
				end
				S_B_CHK: begin
					if ({1'b0, b_col} >= b_cols_e || (upper_q && a_row > b_col)) begin
						k_q <= k_q + FB'(1);
						state_q <= S_B_RD;
					end else begin
						n_q <= b_col;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					sat_q <= sat_q | acc_sat;
					k_q <= k_q + FB'(1);
					state_q <= S_B_RD;
				end
				S_C_RD: begin
					res_value_q <= c_rd_data;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_value_q;
						out_status_q <= res_status_q;
						out_sat_q <= res_sat_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = csp_pkg::OUT_DATA_BITS'(out_value_q);
	assign m_axis_tuser = {out_sat_q, out_status_q};

	`ASSERT_IMPL(a_fill_bound, 1'b1, a_fill_q <= FB'(csp_pkg::MAX_NZ), "A fill past capacity")
	`ASSERT_CLK(busy_after_accept, accept |=> !s_axis_tready, "ready right after an accept")
	`ASSERT_IMPL(sat_only_ok, m_axis_tvalid && m_axis_tuser[2],
		m_axis_tuser[1:0] == csp_pkg::ST_OK, "saturated flag with error status")

endmodule
